/* hdl/utf8ld_pkg.sv */
// ----------------------------------------------------------------------------
// utf8ld_pkg
// Shared types, constants and the lead byte decoder of the UTF-8 detector.
// ----------------------------------------------------------------------------
package utf8ld_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int BYTE_W          = 8;
  localparam int OUT_W           = 16;
  localparam int THR_W           = 7;
  localparam int KIND_W          = 3;
  localparam int MUL_W           = 8;
  localparam int STEP_W          = 3;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [THR_W-1:0] THR_RESET = 7'd90;
  localparam logic [MUL_W-1:0] GOOD_SCALE = 8'd100;

  // Register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;

  // Lead byte prefixes
  localparam logic [2:0] LEAD2_PAT = 3'h6;
  localparam logic [3:0] LEAD3_PAT = 4'hE;
  localparam logic [4:0] LEAD4_PAT = 5'h1E;
  localparam logic [5:0] LEAD5_PAT = 6'h3E;
  localparam logic [6:0] LEAD6_PAT = 7'h7E;
  localparam logic [1:0] CONT_PAT  = 2'h2;

  // Continuations a byte calls for
  localparam logic [KIND_W-1:0] KIND_ASCII = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEQ2  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SEQ3  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEQ4  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEQ5  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SEQ6  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BAD   = 3'd7;

  typedef enum logic [1:0] {
    V_IDLE,
    V_GOOD,
    V_SUM,
    V_HOLD
  } vstate_t;

  typedef struct packed {
    logic idle;
    logic hold;
    logic is_utf8;
  } vstat_t;

  function automatic logic [KIND_W-1:0] lead_kind(input logic [BYTE_W-1:0] b);
    logic [KIND_W-1:0] k;
    if (b[7] == 1'b0)                k = KIND_ASCII;
    else if (b[7:5] == LEAD2_PAT)    k = KIND_SEQ2;
    else if (b[7:4] == LEAD3_PAT)    k = KIND_SEQ3;
    else if (b[7:3] == LEAD4_PAT)    k = KIND_SEQ4;
    else if (b[7:2] == LEAD5_PAT)    k = KIND_SEQ5;
    else if (b[7:1] == LEAD6_PAT)    k = KIND_SEQ6;
    else                             k = KIND_BAD;
    return k;
  endfunction

endpackage

/* hdl/utf8ld_in_if.sv */
// ----------------------------------------------------------------------------
// utf8ld_in_if
// Byte stream channel: valid/ready handshake with byte and end marker.
// ----------------------------------------------------------------------------
interface utf8ld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

/* hdl/utf8ld_out_if.sv */
// ----------------------------------------------------------------------------
// utf8ld_out_if
// Result channel: valid/ready handshake with verdict and both counts.
// ----------------------------------------------------------------------------
interface utf8ld_out_if;
  logic        valid;
  logic        ready;
  logic        is_utf8;
  logic [15:0] good_sequences;
  logic [15:0] bad_bytes;

  modport source (output valid, output is_utf8, output good_sequences,
                  output bad_bytes, input ready);
  modport sink   (input valid, input is_utf8, input good_sequences,
                  input bad_bytes, output ready);
endinterface

/* hdl/utf8ld_scan.sv */
// ----------------------------------------------------------------------------
// utf8ld_scan
// Per-byte sequence tracker with saturating good and bad counters.
// ----------------------------------------------------------------------------
module utf8ld_scan
  import utf8ld_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [BYTE_W-1:0]      byte_value,
  input  logic                   last_byte,
  output logic                   fin_valid,
  output logic [COUNT_WIDTH-1:0] fin_good,
  output logic [COUNT_WIDTH-1:0] fin_bad
);

  localparam int SUM_W = COUNT_WIDTH + 1;

  logic [KIND_W-1:0]      need_r, need_nxt;
  logic [KIND_W-1:0]      seen_r, seen_nxt;
  logic [COUNT_WIDTH-1:0] good_r, good_nxt;
  logic [COUNT_WIDTH-1:0] bad_r, bad_nxt;

  logic [KIND_W-1:0] kind, need_a, seen_a, seen_inc, bad_add;
  logic              cont, good_inc;
  logic [SUM_W-1:0]  good_sum, bad_sum;

  always_comb begin
    cont     = (byte_value[7:6] == CONT_PAT);
    kind     = lead_kind(byte_value);
    seen_inc = seen_r + 3'd1;
    need_a   = need_r;
    seen_a   = seen_r;
    good_inc = 1'b0;
    bad_add  = '0;
    if (need_r != KIND_ASCII && cont) begin
      if (seen_inc >= need_r) begin
        good_inc = 1'b1;
        need_a   = KIND_ASCII;
        seen_a   = '0;
      end else begin
        seen_a = seen_inc;
      end
    end else begin
      // broken sequence: lead plus collected continuations are bad
      if (need_r != KIND_ASCII) bad_add = 3'd1 + seen_r;
      need_a = KIND_ASCII;
      seen_a = '0;
      if (kind == KIND_BAD) begin
        bad_add = bad_add + 3'd1;
      end else if (kind != KIND_ASCII) begin
        need_a = kind;
      end
    end
    // sequence still open at end of stream
    if (last_byte && need_a != KIND_ASCII) bad_add = bad_add + 3'd1 + seen_a;

    good_sum = {1'b0, good_r} + SUM_W'(good_inc);
    bad_sum  = {1'b0, bad_r} + SUM_W'(bad_add);
    fin_good = good_sum[COUNT_WIDTH] ? '1 : good_sum[COUNT_WIDTH-1:0];
    fin_bad  = bad_sum[COUNT_WIDTH] ? '1 : bad_sum[COUNT_WIDTH-1:0];
    fin_valid = accept && last_byte;

    need_nxt = need_r;
    seen_nxt = seen_r;
    good_nxt = good_r;
    bad_nxt  = bad_r;
    if (accept) begin
      if (last_byte) begin
        need_nxt = KIND_ASCII;
        seen_nxt = '0;
        good_nxt = '0;
        bad_nxt  = '0;
      end else begin
        need_nxt = need_a;
        seen_nxt = seen_a;
        good_nxt = fin_good;
        bad_nxt  = fin_bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= KIND_ASCII;
      seen_r <= '0;
      good_r <= '0;
      bad_r  <= '0;
    end else begin
      need_r <= need_nxt;
      seen_r <= seen_nxt;
      good_r <= good_nxt;
      bad_r  <= bad_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid |=> (need_r == KIND_ASCII && seen_r == '0 && good_r == '0 && bad_r == '0))
    else $error("stream state not cleared after last byte");

  a_need_range: assert property (@(posedge clk) disable iff (!rst_n)
    (need_r <= KIND_SEQ6 && seen_r < KIND_SEQ6))
    else $error("sequence tracker out of range");

  a_seen_below_need: assert property (@(posedge clk) disable iff (!rst_n)
    (need_r == KIND_ASCII) ? (seen_r == '0) : (seen_r < need_r))
    else $error("continuation count past the open lead");

endmodule

/* hdl/utf8ld_verdict.sv */
// ----------------------------------------------------------------------------
// utf8ld_verdict
// Shift-add sequencer: sign of 100*good - (threshold+1)*(good+bad).
// ----------------------------------------------------------------------------
module utf8ld_verdict
  import utf8ld_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] good_in,
  input  logic [COUNT_WIDTH-1:0] bad_in,
  input  logic [THR_W-1:0]       threshold,
  input  logic                   take,
  output vstat_t                 stat,
  output logic [COUNT_WIDTH-1:0] good_q,
  output logic [COUNT_WIDTH-1:0] bad_q
);

  localparam int ACC_W = COUNT_WIDTH + 10;

  vstate_t                  state_r, state_nxt;
  logic [STEP_W-1:0]        cnt_r, cnt_nxt;
  logic [MUL_W-1:0]         mbits_r, mbits_nxt;
  logic [ACC_W-1:0]         opnd_r, opnd_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [COUNT_WIDTH-1:0]   good_r, good_nxt;
  logic [COUNT_WIDTH-1:0]   bad_r, bad_nxt;
  logic [ACC_W-1:0]         addend;
  logic                     last_step;

  assign last_step = (cnt_r == '1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      V_IDLE: if (start) state_nxt = V_GOOD;
      V_GOOD: if (last_step) state_nxt = V_SUM;
      V_SUM:  if (last_step) state_nxt = V_HOLD;
      V_HOLD: if (take) state_nxt = V_IDLE;
      default: state_nxt = V_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stat.idle    = (state_r == V_IDLE);
    stat.hold    = (state_r == V_HOLD);
    stat.is_utf8 = ~acc_r[ACC_W-1];
  end

  assign good_q = good_r;
  assign bad_q  = bad_r;

  // shared add/subtract datapath
  always_comb begin
    addend    = mbits_r[0] ? opnd_r : '0;
    cnt_nxt   = cnt_r;
    mbits_nxt = mbits_r;
    opnd_nxt  = opnd_r;
    acc_nxt   = acc_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    unique case (state_r)
      V_IDLE: begin
        if (start) begin
          good_nxt  = good_in;
          bad_nxt   = bad_in;
          opnd_nxt  = ACC_W'(good_in);
          mbits_nxt = GOOD_SCALE;
          acc_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      V_GOOD: begin
        acc_nxt   = acc_r + addend;
        cnt_nxt   = cnt_r + 1'b1;
        opnd_nxt  = opnd_r << 1;
        mbits_nxt = mbits_r >> 1;
        if (last_step) begin
          opnd_nxt  = ACC_W'({1'b0, good_r} + {1'b0, bad_r});
          mbits_nxt = MUL_W'({1'b0, threshold} + 8'd1);
        end
      end
      V_SUM: begin
        acc_nxt   = acc_r - addend;
        cnt_nxt   = cnt_r + 1'b1;
        opnd_nxt  = opnd_r << 1;
        mbits_nxt = mbits_r >> 1;
      end
      V_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= V_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mbits_r <= mbits_nxt;
    opnd_r  <= opnd_nxt;
    acc_r   <= acc_nxt;
    good_r  <= good_nxt;
    bad_r   <= bad_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == V_IDLE)
    else $error("verdict started while busy");

  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == V_HOLD && !take) |=> (state_r == V_HOLD && $stable(acc_r)
      && $stable(good_r) && $stable(bad_r)))
    else $error("held verdict changed");

  a_hold_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == V_SUM && last_step) |=> state_r == V_HOLD && cnt_r == '0)
    else $error("sequencer step count wrong");

endmodule

/* hdl/utf8_likelihood_detector_unit.sv */
// ----------------------------------------------------------------------------
// utf8_likelihood_detector_unit
// Judges whether a byte stream is UTF-8 from counts of good and bad sequences.
// ----------------------------------------------------------------------------
// Usage:
//   in_stream  : one byte per transaction, last_byte marks the end of a stream.
//   out_stream : one transaction per stream, with is_utf8, good_sequences and
//                bad_bytes (counts saturate at 2^COUNT_WIDTH-1, low 16 bits).
//   APB port   : threshold_percent at byte address 0 (7 bits, reset 90).
//                Write only while no stream is in flight.
// Throughput: while the verdict sequencer is idle, a byte that is not last
//   is taken every cycle. After the last byte the sequencer drives one
//   shared add/subtract unit through 8 shift-add steps for 100*good, then 8
//   for (threshold+1)*(good+bad), waits in the hold state until the output
//   register can take the result and moves it there, then returns to idle.
//   in_stream is not ready while the sequencer is busy or holding, so the
//   next stream's first byte waits until it is idle again.
// Stall: a pending result in the output register does not block the next
//   stream; only a second finished verdict waits in the hold state.
// Reset (rst_n, sync): counters and sequence state clear, threshold -> 90,
//   output register empty.
// ----------------------------------------------------------------------------
module utf8_likelihood_detector_unit
  import utf8ld_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  utf8ld_in_if.sink             in_stream,
  utf8ld_out_if.source          out_stream,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [THR_W-1:0]       thr_r, thr_nxt;
  logic                   cfg_wr;

  logic                   in_accept;
  logic                   fin_valid;
  logic [COUNT_WIDTH-1:0] fin_good, fin_bad;
  vstat_t                 vstat;
  logic [COUNT_WIDTH-1:0] good_q, bad_q;
  logic                   take;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_utf8_r, out_utf8_nxt;
  logic [OUT_W-1:0]       out_good_r, out_good_nxt;
  logic [OUT_W-1:0]       out_bad_r, out_bad_nxt;

  // ---- configuration register ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);

  always_comb begin
    thr_nxt = cfg_wr ? pwdata[THR_W-1:0] : thr_r;
    prdata  = (paddr[2] == REG_THRESHOLD) ? CFG_DATA_W'(thr_r) : '0;
  end

  // ---- byte scan ----
  assign in_stream.ready = vstat.idle;
  assign in_accept       = in_stream.valid && in_stream.ready;

  utf8ld_scan #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .byte_value(in_stream.byte_value),
    .last_byte (in_stream.last_byte),
    .fin_valid (fin_valid),
    .fin_good  (fin_good),
    .fin_bad   (fin_bad)
  );

  // ---- verdict sequencer ----
  utf8ld_verdict #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_verdict (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (fin_valid),
    .good_in  (fin_good),
    .bad_in   (fin_bad),
    .threshold(thr_r),
    .take     (take),
    .stat     (vstat),
    .good_q   (good_q),
    .bad_q    (bad_q)
  );

  // move held verdict when the output register is free or draining
  assign take = vstat.hold && (!out_valid_r || out_stream.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_utf8_nxt  = out_utf8_r;
    out_good_nxt  = out_good_r;
    out_bad_nxt   = out_bad_r;
    if (out_valid_r && out_stream.ready) out_valid_nxt = 1'b0;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_utf8_nxt  = vstat.is_utf8;
      out_good_nxt  = OUT_W'(good_q);
      out_bad_nxt   = OUT_W'(bad_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_utf8_r <= out_utf8_nxt;
    out_good_r <= out_good_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_stream.valid          = out_valid_r;
  assign out_stream.is_utf8        = out_utf8_r;
  assign out_stream.good_sequences = out_good_r;
  assign out_stream.bad_bytes      = out_bad_r;

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_stream.last_byte) |=> !in_stream.ready)
    else $error("input taken while verdict pending");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("verdict transaction lost");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (!out_valid_r || out_stream.ready))
    else $error("output register overwritten");

endmodule

/* verif/utf8_likelihood_detector_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_likelihood_detector_unit_test
// Self-checking bench for the UTF-8 likelihood detector. A byte-level
// predictor follows every accepted byte and produces the verdict due at each
// end of stream. Each verdict leaving the block is compared field by field
// with the oldest expected verdict. The stimulus has four parts: a short
// scripted part, random streams under several thresholds, a long output
// hold, and a closing set of streams with no idling on either side.
// ----------------------------------------------------------------------------
module utf8_likelihood_detector_unit_test;
  import utf8ld_pkg::*;

  localparam int HALF_PERIOD    = 1;
  localparam int RESET_CYCLES   = 6;
  localparam int CNT_W          = COUNT_WIDTH_DEF;
  localparam longint unsigned CNT_MAX   = (64'd1 << CNT_W) - 1;
  localparam longint unsigned PCT_SCALE = 100;
  localparam logic [CFG_ADDR_W-1:0] THR_ADDR = {REG_THRESHOLD, 2'b00};

  // Extra wait once drained, with margin over the sequencer latency.
  localparam int SETTLE_CYCLES  = 24;
  // Longest correct stretch with no transaction is the forced output hold.
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam int N_PHASES       = 5;
  localparam int PHASE_BYTES    = 240;
  localparam int PRESSURE_PHASE = 3;
  localparam int DIRECTED_ROWS  = 27;

  typedef struct packed {
    logic             is_utf8;
    logic [OUT_W-1:0] good;
    logic [OUT_W-1:0] bad;
  } verdict_t;

  typedef struct packed {
    logic             pinned;
    verdict_t         v;
  } pin_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              last;
    logic              pinned;
    logic              is_utf8;
    logic [OUT_W-1:0]  good;
    logic [OUT_W-1:0]  bad;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  // APB configuration port
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  utf8ld_in_if  in_ch ();
  utf8ld_out_if out_ch ();

  utf8_likelihood_detector_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: open sequence, both counts and the threshold copy
  // --------------------------------------------------------------------------
  logic [KIND_W-1:0] seq_need = KIND_ASCII;  // continuations the open lead wants
  logic [KIND_W-1:0] seq_seen = '0;          // continuations taken so far
  logic [CNT_W-1:0]  good_cnt = '0;
  logic [CNT_W-1:0]  bad_cnt  = '0;
  logic [THR_W-1:0]  thr_cfg  = THR_RESET;

  verdict_t verdicts_due[$];  // verdicts owed by the block, oldest first
  pin_t     pin_q[$];         // one entry per end-of-stream byte sent

  // Pacing controls shared between the stimulus and the result sink
  bit sender_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  bit hold_req    = 1'b0;

  int unsigned mismatches = 0;
  int unsigned bytes_taken = 0;
  int unsigned verdicts_checked = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [CNT_W-1:0] count_add(input logic [CNT_W-1:0] c,
                                                 input int unsigned n);
    longint unsigned s;
    s = longint'(c) + n;
    return CNT_W'((s > CNT_MAX) ? CNT_MAX : s);
  endfunction

  // A sequence given up on charges its lead and every continuation taken.
  function automatic void drop_open_seq();
    if (seq_need != KIND_ASCII)
      bad_cnt = count_add(bad_cnt, 1 + seq_seen);
    seq_need = KIND_ASCII;
    seq_seen = '0;
  endfunction

  // Advances the predictor by one byte; returns 1 when a verdict is due.
  function automatic bit scan_byte(input logic [BYTE_W-1:0] b, input logic last,
                                   output verdict_t v);
    logic [KIND_W-1:0] kind;
    bit                absorbed;
    longint unsigned   pct;
    absorbed = 1'b0;
    v = '0;
    if (seq_need != KIND_ASCII) begin
      if (b[7:6] == CONT_PAT) begin
        seq_seen = seq_seen + 1'b1;
        if (seq_seen >= seq_need) begin
          good_cnt = count_add(good_cnt, 1);
          seq_need = KIND_ASCII;
          seq_seen = '0;
        end
        absorbed = 1'b1;
      end else begin
        // broken sequence: this byte is looked at again as a lead
        drop_open_seq();
      end
    end
    if (!absorbed) begin
      casez (b)
        8'b0???????: kind = KIND_ASCII;
        8'b110?????: kind = KIND_SEQ2;
        8'b1110????: kind = KIND_SEQ3;
        8'b11110???: kind = KIND_SEQ4;
        8'b111110??: kind = KIND_SEQ5;
        8'b1111110?: kind = KIND_SEQ6;
        default:     kind = KIND_BAD;
      endcase
      if (kind == KIND_BAD) begin
        bad_cnt = count_add(bad_cnt, 1);
      end else if (kind != KIND_ASCII) begin
        seq_need = kind;
        seq_seen = '0;
      end
    end
    if (!last)
      return 1'b0;
    drop_open_seq();  // unfinished at end of stream
    if (good_cnt == '0 && bad_cnt == '0) begin
      v.is_utf8 = 1'b1;
    end else begin
      pct = (PCT_SCALE * longint'(good_cnt)) / (longint'(good_cnt) + longint'(bad_cnt));
      v.is_utf8 = (pct > longint'(thr_cfg));
    end
    v.good = good_cnt[OUT_W-1:0];
    v.bad  = bad_cnt[OUT_W-1:0];
    good_cnt = '0;
    bad_cnt  = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predicts on each input transaction, checks each output
  // transaction, and guards against a hang.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    verdict_t pred;
    verdict_t want;
    verdict_t got;
    pin_t     pin;
    bit       moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        bytes_taken++;
        if (scan_byte(in_ch.byte_value, in_ch.last_byte, pred)) begin
          pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
          verdicts_due.push_back(pin.pinned ? pin.v : pred);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        got.is_utf8 = out_ch.is_utf8;
        got.good    = out_ch.good_sequences;
        got.bad     = out_ch.bad_bytes;
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict: is_utf8 %0d good %0d bad %0d",
                   $time, got.is_utf8, got.good, got.bad);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          verdicts_checked++;
          if (got.is_utf8 !== want.is_utf8) begin
            $display("%0t: is_utf8 expected %0d, actual %0d", $time, want.is_utf8,
                     got.is_utf8);
            mismatches++;
          end
          if (got.good !== want.good) begin
            $display("%0t: good_sequences expected %0d, actual %0d", $time, want.good,
                     got.good);
            mismatches++;
          end
          if (got.bad !== want.bad) begin
            $display("%0t: bad_bytes expected %0d, actual %0d", $time, want.bad,
                     got.bad);
            mismatches++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("utf8_likelihood_detector_unit: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts, plus one long hold on
  // request, counted here, that backs the block up into its input.
  // --------------------------------------------------------------------------
  initial begin : sink_pacing
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Offers one byte and returns at the edge where the transaction completes.
  // An end-of-stream byte may carry a verdict typed in by hand.
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last,
                           input logic pinned = 1'b0, input verdict_t pin_v = '0);
    int unsigned pause;
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      pause = $urandom_range(1, 14);
      repeat (pause) @(posedge clk);
    end
    if (last)
      pin_q.push_back('{pinned, pin_v});
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.last_byte  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Waits out every owed verdict, then the sequencer latency.
  task automatic drain();
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_threshold(input logic [THR_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= THR_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== CFG_DATA_W'(want)) begin
      $display("%0t: threshold readback expected %0d, actual %0d", $time, want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are random; only the low 7 bits belong to the register.
  task automatic program_threshold(input logic [THR_W-1:0] thr);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[THR_W-1:0] = thr;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THR_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    thr_cfg = thr;
    check_threshold(thr);
  endtask

  // Scripted opening at the reset threshold of 90.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // pure ASCII stream: nothing counted, judged UTF-8
    '{8'h00, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0},
    // 0xFF, 0xFE and a stray continuation are each one bad byte
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'hFE, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b1, 1'b1, 1'b0, 16'd0, 16'd3},
    // one complete sequence of every length, 2 up to 6 bytes
    '{8'hC2, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'hE0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'hF0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'hF8, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'hFC, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 16'd5, 16'd0},
    // broken after one continuation, then the breaker left open at the end
    '{8'hE1, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{8'hC3, 1'b1, 1'b1, 1'b0, 16'd0, 16'd3}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [THR_W-1:0]  phase_thr [N_PHASES];
    logic [BYTE_W-1:0] stream[$];
    logic [BYTE_W-1:0] lead;
    int unsigned       phase_bytes;
    int unsigned       tokens;
    int unsigned       pick;
    int unsigned       cont_n;
    int unsigned       cut;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.byte_value <= '0;
    in_ch.last_byte  <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;

    // threshold extremes first, then two random settings
    phase_thr[0] = 7'd0;
    phase_thr[1] = 7'd100;
    phase_thr[2] = 7'd127;
    phase_thr[3] = THR_W'($urandom_range(1, 99));
    phase_thr[4] = THR_W'($urandom_range(1, 99));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_threshold(THR_RESET);

    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    foreach (directed_rows[i])
      push_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].pinned,
                '{directed_rows[i].is_utf8, directed_rows[i].good, directed_rows[i].bad});
    in_ch.valid <= 1'b0;
    drain();

    // Random streams: mostly well-formed sequences with random payload bits,
    // the rest truncated sequences, stray continuations, 0xFE/0xFF and random bytes.
    // The last phase runs with no idling on either side.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      program_threshold(phase_thr[phase]);
      if (phase == PRESSURE_PHASE)
        hold_req = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
        stream.delete();
        repeat (tokens) begin
          pick = $urandom_range(0, 99);
          if (pick < 25) begin
            stream.push_back(BYTE_W'($urandom_range(0, 127)));
          end else if (pick < 80) begin
            cont_n = $urandom_range(1, 5);
            lead = BYTE_W'((8'hFF << (7 - cont_n)) | ($urandom & (8'hFF >> (cont_n + 2))));
            stream.push_back(lead);
            cut = (pick < 65) ? cont_n : $urandom_range(0, cont_n - 1);
            repeat (cut) stream.push_back(BYTE_W'(8'h80 | ($urandom & 8'h3F)));
          end else if (pick < 90) begin
            stream.push_back(BYTE_W'(8'h80 | ($urandom & 8'h3F)));
          end else if (pick < 95) begin
            stream.push_back(BYTE_W'(8'hFE | $urandom_range(0, 1)));
          end else begin
            stream.push_back(BYTE_W'($urandom_range(0, 255)));
          end
        end
        if (phase == N_PHASES - 1) begin
          sender_gaps = 1'b0;
          sink_stalls = 1'b0;
        end else begin
          sender_gaps = ($urandom_range(0, 3) != 0);
          sink_stalls = ($urandom_range(0, 3) != 0);
        end
        foreach (stream[j])
          push_byte(stream[j], j == stream.size() - 1);
        phase_bytes += stream.size();
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    $display("%0d verdicts checked over %0d bytes: scripted cases, random streams",
             verdicts_checked, bytes_taken);
    $display("at thresholds 0/100/127/random, a %0d-cycle output hold, a gap-free finish",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("utf8_likelihood_detector_unit: match");
    else
      $display("utf8_likelihood_detector_unit: mismatch");
    $finish;
  end

endmodule
